// File: src/act_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package act_pkg;

    localparam int NUM_LISTS      = 4;
    localparam int ENT_W          = 63;
    localparam int COMP_W         = 32;
    localparam int LIST_DEPTH_DEF = 16;

    // list numbers
    localparam logic [1:0] LIST_GAINED   = 2'd0;
    localparam logic [1:0] LIST_LOST     = 2'd1;
    localparam logic [1:0] LIST_IMMINENT = 2'd2;
    localparam logic [1:0] LIST_TEMP     = 2'd3;

    // commands
    localparam logic [2:0] CMD_SET_AUTH   = 3'd0;
    localparam logic [2:0] CMD_REMOVE_CMP = 3'd1;
    localparam logic [2:0] CMD_REMOVE_ENT = 3'd2;
    localparam logic [2:0] CMD_CLEAR      = 3'd3;
    localparam logic [2:0] CMD_READ       = 3'd4;

    // authority levels
    localparam logic [1:0] LVL_NOT_AUTH  = 2'd0;
    localparam logic [1:0] LVL_AUTH      = 2'd1;
    localparam logic [1:0] LVL_IMMINENT  = 2'd2;

    typedef struct packed {
        logic drop_pair;
        logic drop_ent;
        logic append;
        logic clear;
    } act_row_ctl_t;

    typedef struct packed {
        logic hit_pair;
        logic hit_ent;
        logic full;
    } act_row_sts_t;

    typedef enum logic {
        ST_IDLE,
        ST_STRIP
    } act_state_t;

endpackage

`default_nettype wire

// File: src/act_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module act_cell (
    input  logic                       aclk,
    input  logic                       ld,
    input  logic [act_pkg::ENT_W-1:0]  din_ent,
    input  logic [act_pkg::COMP_W-1:0] din_comp,
    input  logic [act_pkg::ENT_W-1:0]  key_ent,
    input  logic [act_pkg::COMP_W-1:0] key_comp,
    output logic [act_pkg::ENT_W-1:0]  q_ent,
    output logic [act_pkg::COMP_W-1:0] q_comp,
    output logic                       match_pair,
    output logic                       match_ent
);
    import act_pkg::*;

    logic [ENT_W-1:0]  ent_reg;
    logic [COMP_W-1:0] comp_reg;

    always_ff @(posedge aclk) begin
        if (ld) begin
            ent_reg  <= din_ent;
            comp_reg <= din_comp;
        end
    end

    assign q_ent      = ent_reg;
    assign q_comp     = comp_reg;
    assign match_ent  = (ent_reg == key_ent);
    assign match_pair = match_ent && (comp_reg == key_comp);

endmodule

`default_nettype wire

// File: src/act_row.sv
`timescale 1ns / 1ps
`default_nettype none

module act_row #(
    parameter int LIST_DEPTH = act_pkg::LIST_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  act_pkg::act_row_ctl_t               ctl,
    input  logic [act_pkg::ENT_W-1:0]           key_ent,
    input  logic [act_pkg::COMP_W-1:0]          key_comp,
    input  logic [$clog2(LIST_DEPTH)-1:0]       rd_idx,
    output act_pkg::act_row_sts_t               sts,
    output logic [$clog2(LIST_DEPTH+1)-1:0]     len_q,
    output logic [$clog2(LIST_DEPTH+1)-1:0]     len_next,
    output logic [act_pkg::ENT_W-1:0]           rd_ent,
    output logic [act_pkg::COMP_W-1:0]          rd_comp
);
    import act_pkg::*;

    localparam int LW = $clog2(LIST_DEPTH + 1);

    logic [LW-1:0]     len_reg;
    logic [ENT_W-1:0]  cell_ent  [LIST_DEPTH];
    logic [COMP_W-1:0] cell_comp [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] live;
    logic [LIST_DEPTH-1:0] m_pair;
    logic [LIST_DEPTH-1:0] m_ent;
    logic [LIST_DEPTH-1:0] hit;
    logic drop_any;
    logic full;
    logic hit_any;

    assign drop_any = ctl.drop_pair || ctl.drop_ent;
    assign full     = (len_reg == LW'(LIST_DEPTH));
    assign hit      = live & (ctl.drop_ent ? m_ent : m_pair);
    assign hit_any  = |hit;

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic              ld;
        logic              shift;
        logic              put;
        logic [ENT_W-1:0]  nb_ent;
        logic [COMP_W-1:0] nb_comp;

        assign live[i] = (LW'(i) < len_reg);
        // everything at or after the first hit moves one place toward the head
        assign shift   = drop_any && (|hit[i:0]);
        assign put     = ctl.append && !full && (LW'(i) == len_reg);
        assign ld      = shift || put;

        if (i < LIST_DEPTH - 1) begin : g_nb
            assign nb_ent  = cell_ent[i+1];
            assign nb_comp = cell_comp[i+1];
        end else begin : g_tail
            assign nb_ent  = cell_ent[i];
            assign nb_comp = cell_comp[i];
        end

        act_cell u_cell (
            .aclk       (aclk),
            .ld         (ld),
            .din_ent    (put ? key_ent : nb_ent),
            .din_comp   (put ? key_comp : nb_comp),
            .key_ent    (key_ent),
            .key_comp   (key_comp),
            .q_ent      (cell_ent[i]),
            .q_comp     (cell_comp[i]),
            .match_pair (m_pair[i]),
            .match_ent  (m_ent[i])
        );
    end

    always_comb begin
        len_next = len_reg;
        priority if (ctl.clear) begin
            len_next = '0;
        end else if (drop_any && hit_any) begin
            len_next = len_reg - LW'(1);
        end else if (ctl.append && !full) begin
            len_next = len_reg + LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

    assign len_q        = len_reg;
    assign sts.hit_pair = |(live & m_pair);
    assign sts.hit_ent  = |(live & m_ent);
    assign sts.full     = full;
    assign rd_ent       = cell_ent[rd_idx];
    assign rd_comp      = cell_comp[rd_idx];

endmodule

`default_nettype wire

// File: src/authority_change_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Four ordered lists (gained, lost, loss imminent, lost temporarily) of
// entity/component pairs, each a row of LIST_DEPTH cells that compare the
// key in parallel and close gaps by shifting toward the head. Set authority,
// remove component, clear and read give their result in the cycle after they
// are accepted, so a new item can be accepted every cycle while the result
// side keeps up and no remove entity runs; every item returns exactly one
// result. Remove entity holds off new items while each row drops one match
// of that entity per cycle, until no match is left and the result side is
// free. Entries past a list's length hold stale data and are never returned.
module authority_change_tracker #(
    parameter int LIST_DEPTH = act_pkg::LIST_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_cmd,
    input  logic [act_pkg::ENT_W-1:0]   s_entity_id,
    input  logic [act_pkg::COMP_W-1:0]  s_component_id,
    input  logic [1:0]                  s_authority_level,
    input  logic [1:0]                  s_list_select,
    input  logic [3:0]                  s_read_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_read_valid,
    output logic [act_pkg::ENT_W-1:0]   m_read_entity,
    output logic [act_pkg::COMP_W-1:0]  m_read_component,
    output logic [4:0]                  m_list_length,
    output logic                        m_overflow
);
    import act_pkg::*;

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam int XW = (LW > 5) ? LW : 5;

    act_state_t state_reg, state_next;

    act_row_ctl_t ctl     [NUM_LISTS];
    act_row_sts_t sts     [NUM_LISTS];
    logic [LW-1:0]     len_q    [NUM_LISTS];
    logic [LW-1:0]     len_nx   [NUM_LISTS];
    logic [ENT_W-1:0]  row_ent  [NUM_LISTS];
    logic [COMP_W-1:0] row_comp [NUM_LISTS];

    logic [ENT_W-1:0] ent_reg;
    logic [1:0]       sel_reg;
    logic [ENT_W-1:0] key_ent;
    logic [1:0]       sel;
    logic [XW-1:0]    idx_x;
    logic [XW-1:0]    len_x;
    logic             s_acc;
    logic             out_free;
    logic             strip_hit;
    logic             res_load;

    logic             m_valid_reg, m_valid_next;
    logic             rd_valid_reg;
    logic [ENT_W-1:0] rd_ent_reg;
    logic [COMP_W-1:0] rd_comp_reg;
    logic [4:0]       len_out_reg;
    logic             ovf_reg;

    logic             rd_valid_c;
    logic [ENT_W-1:0] rd_ent_c;
    logic [COMP_W-1:0] rd_comp_c;
    logic             ovf_c;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_acc     = s_valid && s_ready;
    assign key_ent   = (state_reg == ST_STRIP) ? ent_reg : s_entity_id;
    assign sel       = (state_reg == ST_STRIP) ? sel_reg : s_list_select;
    assign strip_hit = sts[0].hit_ent || sts[1].hit_ent || sts[2].hit_ent
                       || sts[3].hit_ent;

    for (genvar l = 0; l < NUM_LISTS; l++) begin : g_row
        act_row #(
            .LIST_DEPTH (LIST_DEPTH)
        ) u_row (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl[l]),
            .key_ent  (key_ent),
            .key_comp (s_component_id),
            .rd_idx   (idx_x[IW-1:0]),
            .sts      (sts[l]),
            .len_q    (len_q[l]),
            .len_next (len_nx[l]),
            .rd_ent   (row_ent[l]),
            .rd_comp  (row_comp[l])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_cmd == CMD_REMOVE_ENT) begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (!strip_hit && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and row controls
    always_comb begin
        s_ready  = 1'b0;
        res_load = 1'b0;
        for (int l = 0; l < NUM_LISTS; l++) begin
            ctl[l] = '0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = out_free;
                res_load = s_valid && out_free && (s_cmd != CMD_REMOVE_ENT);
                if (s_valid && out_free) begin
                    unique case (s_cmd)
                        CMD_SET_AUTH: begin
                            unique case (s_authority_level)
                                LVL_NOT_AUTH: begin
                                    ctl[LIST_IMMINENT].drop_pair = 1'b1;
                                    ctl[LIST_TEMP].drop_pair     = 1'b1;
                                    ctl[LIST_GAINED].drop_pair   = 1'b1;
                                    ctl[LIST_LOST].append = !sts[LIST_GAINED].hit_pair;
                                end
                                LVL_AUTH: begin
                                    if (sts[LIST_LOST].hit_pair) begin
                                        ctl[LIST_LOST].drop_pair = 1'b1;
                                        ctl[LIST_TEMP].append    = 1'b1;
                                    end else begin
                                        ctl[LIST_GAINED].append  = 1'b1;
                                    end
                                end
                                LVL_IMMINENT: begin
                                    ctl[LIST_IMMINENT].append = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        CMD_REMOVE_CMP: begin
                            for (int l = 0; l < NUM_LISTS; l++) begin
                                ctl[l].drop_pair = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            for (int l = 0; l < NUM_LISTS; l++) begin
                                ctl[l].clear = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_STRIP: begin
                for (int l = 0; l < NUM_LISTS; l++) begin
                    ctl[l].drop_ent = 1'b1;
                end
                res_load = !strip_hit && out_free;
            end
            default: ;
        endcase
    end

    // result fields
    assign idx_x = XW'(s_read_index);
    assign len_x = XW'(len_q[s_list_select]);

    always_comb begin
        rd_valid_c = (state_reg == ST_IDLE) && (s_cmd == CMD_READ) && (idx_x < len_x);
        rd_ent_c   = rd_valid_c ? row_ent[s_list_select] : '0;
        rd_comp_c  = rd_valid_c ? row_comp[s_list_select] : '0;
        ovf_c      = 1'b0;
        for (int l = 0; l < NUM_LISTS; l++) begin
            ovf_c = ovf_c || (ctl[l].append && sts[l].full);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            ent_reg <= s_entity_id;
            sel_reg <= s_list_select;
        end
        if (res_load) begin
            rd_valid_reg <= rd_valid_c;
            rd_ent_reg   <= rd_ent_c;
            rd_comp_reg  <= rd_comp_c;
            len_out_reg  <= 5'(len_nx[sel]);
            ovf_reg      <= ovf_c;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_read_valid     = rd_valid_reg;
    assign m_read_entity    = rd_ent_reg;
    assign m_read_component = rd_comp_reg;
    assign m_list_length    = len_out_reg;
    assign m_overflow       = ovf_reg;

`ifndef SYNTHESIS
    a_strip_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STRIP && !strip_hit && out_free)
        |=> (state_reg == ST_IDLE && m_valid_reg))
        else $error("remove entity did not finish with a result");

    a_ovf_not_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ovf_reg) |-> !rd_valid_reg)
        else $error("overflow flagged on a read result");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_cmd == CMD_CLEAR)
        |=> (len_q[0] == '0 && len_q[1] == '0 && len_q[2] == '0 && len_q[3] == '0))
        else $error("clear left a list non-empty");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_q[0] <= LW'(LIST_DEPTH) && len_q[1] <= LW'(LIST_DEPTH)
         && len_q[2] <= LW'(LIST_DEPTH) && len_q[3] <= LW'(LIST_DEPTH)))
        else $error("list length beyond depth");
`endif

endmodule

`default_nettype wire
